### sv/rwc_pkg.sv
// Shared types and constants for the rolling window checksum block.
// No dependencies; every other file of the block imports this package.
package rwc_pkg;

	localparam int BYTE_W = 8;
	localparam int SUM_W = 16;
	localparam int CSUM_W = 2 * SUM_W;
	localparam int CFG_W = 13;
	localparam int DEF_MAX_WINDOW = 4096;
	localparam logic [CFG_W-1:0] DEF_WINDOW_LEN = 13'd1024;
	localparam int OUT_DEPTH = 4;
	localparam int OCC_W = $clog2(OUT_DEPTH + 1) + 1;

	typedef struct packed {
		logic restart;
		logic full_before;
		logic full_after;
		logic [SUM_W-1:0] n_lo;
		logic [BYTE_W-1:0] byte_new;
	} rwc_ctl_t;

	typedef struct packed {
		logic [CSUM_W-1:0] checksum;
		logic window_full;
	} rwc_res_t;

endpackage

### sv/rolling_window_checksum.sv
// Rolling window checksum: one byte per transfer, one result (a + (b << 16) and a window-full
// flag) per byte, in order. The block takes one byte every cycle; a result passes through the
// sum pipeline into the result queue, from which it is presented. The rate is set by
// the window store, which reads the oldest byte and writes the new byte in the same cycle. A
// four-entry result queue absorbs output stalls; the input stalls only when that queue and the
// pipeline together hold four results. The store needs no clearing pass after reset. Write
// window_len only while no transfer is in progress.
module rolling_window_checksum import rwc_pkg::*; #(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic in_valid,
	output logic in_ready,
	input  logic [BYTE_W-1:0] byte_in,
	input  logic restart,
	output logic out_valid,
	input  logic out_ready,
	output logic [CSUM_W-1:0] checksum,
	output logic window_full
);

	localparam int AW = $clog2(MAX_WINDOW);
	localparam int FW = $clog2(MAX_WINDOW + 1);
	localparam int PW = FW + 1;
	localparam logic [31:0] MAXW32 = 32'(MAX_WINDOW);

	logic [CFG_W-1:0] window_len_q;
	logic [AW-1:0] write_pos_q;
	logic [FW-1:0] fill_q;
	logic [FW-1:0] n_eff;
	logic [AW-1:0] pos;
	logic [FW-1:0] fill_cur;
	logic [FW-1:0] fill_next;
	logic [PW-1:0] pos_x;
	logic [PW-1:0] n_x;
	logic [PW-1:0] old_x;
	logic take;
	rwc_ctl_t ctl;
	logic [BYTE_W-1:0] old_byte;
	logic res_valid;
	rwc_res_t res;
	rwc_res_t head;
	logic [1:0] inflight;
	logic [$clog2(OUT_DEPTH+1)-1:0] q_count;
	logic [OCC_W-1:0] occupancy;

	always_comb begin
		if (window_len_q == '0) begin
			n_eff = FW'(1);
		end else if (32'(window_len_q) > MAXW32) begin
			n_eff = FW'(MAX_WINDOW);
		end else begin
			n_eff = FW'(window_len_q);
		end
	end

	assign pos = restart ? '0 : write_pos_q;
	assign fill_cur = restart ? '0 : fill_q;
	assign pos_x = PW'(pos);
	assign n_x = PW'(n_eff);
	assign old_x = (pos_x >= n_x) ? pos_x - n_x : pos_x + PW'(MAX_WINDOW) - n_x;

	assign ctl.restart = restart;
	assign ctl.full_before = fill_cur >= n_eff;
	assign fill_next = ctl.full_before ? fill_cur : fill_cur + 1'b1;
	assign ctl.full_after = fill_next >= n_eff;
	assign ctl.n_lo = SUM_W'(n_eff);
	assign ctl.byte_new = byte_in;

	assign occupancy = OCC_W'(inflight) + OCC_W'(q_count);
	assign in_ready = occupancy < OCC_W'(OUT_DEPTH);
	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= DEF_WINDOW_LEN;
			write_pos_q <= '0;
			fill_q <= '0;
		end else begin
			if (cfg_we) begin
				window_len_q <= cfg_wdata;
			end
			if (take) begin
				write_pos_q <= (pos == AW'(MAX_WINDOW - 1)) ? '0 : pos + 1'b1;
				fill_q <= fill_next;
			end
		end
	end

	rwc_window_mem #(
		.DEPTH(MAX_WINDOW),
		.AW(AW)
	) u_mem (
		.clk(clk),
		.wr_en(take),
		.wr_addr(pos),
		.wr_data(byte_in),
		.rd_en(take),
		.rd_addr(AW'(old_x)),
		.rd_data(old_byte)
	);

	rwc_sum_pipe u_sum (
		.clk(clk),
		.arst_n(arst_n),
		.in_take(take),
		.in_ctl(ctl),
		.old_byte(old_byte),
		.res_valid(res_valid),
		.res(res),
		.inflight(inflight)
	);

	rwc_out_fifo #(
		.DEPTH(OUT_DEPTH)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(res_valid),
		.push_data(res),
		.pop(out_ready),
		.not_empty(out_valid),
		.head_data(head),
		.count(q_count)
	);

	assign checksum = head.checksum;
	assign window_full = head.window_full;

	property p_occupancy;
		@(posedge clk) disable iff (!arst_n) occupancy <= OCC_W'(OUT_DEPTH);
	endproperty
	a_occupancy: assert property (p_occupancy)
		else $error("more results in flight than queue room");

	property p_pos_range;
		@(posedge clk) disable iff (!arst_n)
			write_pos_q < AW'(MAX_WINDOW - 1) || write_pos_q == AW'(MAX_WINDOW - 1);
	endproperty
	a_pos_range: assert property (p_pos_range) else $error("write position out of range");

	property p_fill_range;
		@(posedge clk) disable iff (!arst_n) fill_q <= FW'(MAX_WINDOW);
	endproperty
	a_fill_range: assert property (p_fill_range) else $error("fill count beyond window store");

	property p_fill_holds_when_full;
		@(posedge clk) disable iff (!arst_n)
			take && ctl.full_before |=> fill_q == $past(fill_q);
	endproperty
	a_fill_holds_when_full: assert property (p_fill_holds_when_full)
		else $error("fill count moved on a full window");

endmodule

### sv/rwc_window_mem.sv
// Byte store that holds the sliding window: one write port, one registered read port.
// Reads return the old contents when read and write hit the same entry. Uses rwc_pkg.
module rwc_window_mem import rwc_pkg::*; #(
	parameter int DEPTH = DEF_MAX_WINDOW,
	parameter int AW = $clog2(DEF_MAX_WINDOW)
) (
	input  logic clk,
	input  logic wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

endmodule

### sv/rwc_sum_pipe.sv
// Two-stage sum update: the first stage forms the deltas from the oldest byte,
// the second keeps sum a and sum b and emits one result per item. Uses rwc_pkg.
module rwc_sum_pipe import rwc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_take,
	input  rwc_ctl_t in_ctl,
	input  logic [BYTE_W-1:0] old_byte,
	output logic res_valid,
	output rwc_res_t res,
	output logic [1:0] inflight
);

	logic valid_s1;
	rwc_ctl_t ctl_s1;
	logic valid_s2;
	logic restart_s2;
	logic full_s2;
	logic [SUM_W-1:0] da_s2;
	logic [SUM_W-1:0] nx_s2;
	logic [SUM_W-1:0] sum_a_q;
	logic [SUM_W-1:0] sum_b_q;
	logic [SUM_W-1:0] da;
	logic [SUM_W-1:0] nx;
	logic [SUM_W-1:0] a_base;
	logic [SUM_W-1:0] b_base;
	logic [SUM_W-1:0] a_new;
	logic [SUM_W-1:0] b_new;

	always_comb begin
		if (ctl_s1.full_before) begin
			da = SUM_W'(ctl_s1.byte_new) - SUM_W'(old_byte);
			nx = ctl_s1.n_lo * SUM_W'(old_byte);
		end else begin
			da = SUM_W'(ctl_s1.byte_new);
			nx = '0;
		end
	end

	assign a_base = restart_s2 ? '0 : sum_a_q;
	assign b_base = restart_s2 ? '0 : sum_b_q;
	assign a_new = a_base + da_s2;
	assign b_new = b_base - nx_s2 + a_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			sum_a_q <= '0;
			sum_b_q <= '0;
		end else begin
			valid_s1 <= in_take;
			valid_s2 <= valid_s1;
			if (valid_s2) begin
				sum_a_q <= a_new;
				sum_b_q <= b_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			ctl_s1 <= in_ctl;
		end
		if (valid_s1) begin
			da_s2 <= da;
			nx_s2 <= nx;
			restart_s2 <= ctl_s1.restart;
			full_s2 <= ctl_s1.full_after;
		end
	end

	assign res_valid = valid_s2;
	assign res.checksum = {b_new, a_new};
	assign res.window_full = full_s2;
	assign inflight = 2'(valid_s1) + 2'(valid_s2);

	property p_s2_follows_s1;
		@(posedge clk) disable iff (!arst_n) valid_s1 |=> valid_s2;
	endproperty
	a_s2_follows_s1: assert property (p_s2_follows_s1) else $error("stage 2 lost an item");

	property p_sum_hold;
		@(posedge clk) disable iff (!arst_n)
			!valid_s2 |=> (sum_a_q == $past(sum_a_q)) && (sum_b_q == $past(sum_b_q));
	endproperty
	a_sum_hold: assert property (p_sum_hold) else $error("sums changed without an item");

	property p_partial_no_mult;
		@(posedge clk) disable iff (!arst_n)
			valid_s1 && !ctl_s1.full_before |=> nx_s2 == '0;
	endproperty
	a_partial_no_mult: assert property (p_partial_no_mult) else $error("oldest byte removed early");

endmodule

### sv/rwc_out_fifo.sv
// Small result queue that decouples the sum pipeline from the output handshake.
// Holds rwc_res_t entries from rwc_pkg; the caller keeps it from overflowing.
module rwc_out_fifo import rwc_pkg::*; #(
	parameter int DEPTH = OUT_DEPTH
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rwc_res_t push_data,
	input  logic pop,
	output logic not_empty,
	output rwc_res_t head_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	rwc_res_t buf_q [DEPTH];
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic do_pop;

	assign not_empty = count_q != '0;
	assign do_pop = pop && not_empty;
	assign head_data = buf_q[head_q];
	assign count = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				tail_q <= (tail_q == PW'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= (head_q == PW'(DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[tail_q] <= push_data;
		end
	end

	property p_no_overflow;
		@(posedge clk) disable iff (!arst_n) push && !do_pop |-> count_q < CW'(DEPTH);
	endproperty
	a_no_overflow: assert property (p_no_overflow) else $error("result queue overflow");

	property p_count_tracks;
		@(posedge clk) disable iff (!arst_n)
			(push && !do_pop) |=> count_q == $past(count_q) + 1'b1;
	endproperty
	a_count_tracks: assert property (p_count_tracks) else $error("queue count slipped");

	property p_ptr_range;
		@(posedge clk) disable iff (!arst_n)
			(int'(head_q) < DEPTH) && (int'(tail_q) < DEPTH);
	endproperty
	a_ptr_range: assert property (p_ptr_range) else $error("queue pointer out of range");

endmodule

### tb/rolling_window_checksum_test.sv
`timescale 1ns / 1ps
// Testbench for rolling_window_checksum: sends bytes with random gaps and output stalls,
// predicts every checksum and window-full flag, and compares each result transfer in order.
// Depends on rwc_pkg and the rolling_window_checksum module.
module rolling_window_checksum_test;
	import rwc_pkg::*;

	localparam int WINDOW_DEPTH = DEF_MAX_WINDOW;
	localparam int unsigned CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [BYTE_W-1:0] byte_in = '0;
	logic restart = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [CSUM_W-1:0] checksum;
	logic window_full;

	logic [BYTE_W-1:0] model_store [WINDOW_DEPTH];
	int unsigned model_wpos;
	int unsigned model_fill;
	logic [SUM_W-1:0] model_sum_a;
	logic [SUM_W-1:0] model_sum_b;
	logic [CFG_W-1:0] model_window_len;

	logic [CSUM_W-1:0] expected_checksum [$];
	logic expected_full [$];
	int fail_count = 0;
	int unsigned cycle_count = 0;
	bit no_idle = 1'b0;

	rolling_window_checksum dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_in(byte_in),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.checksum(checksum),
		.window_full(window_full)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("rolling_window_checksum test failed");
			$finish;
		end
	end

	task automatic reset_model();
		for (int i = 0; i < WINDOW_DEPTH; i++) model_store[i] = '0;
		model_wpos = 0;
		model_fill = 0;
		model_sum_a = '0;
		model_sum_b = '0;
		model_window_len = DEF_WINDOW_LEN;
	endtask

	task automatic predict_checksum(input logic [BYTE_W-1:0] b, input logic r);
		int unsigned n;
		int unsigned old_pos;
		logic [BYTE_W-1:0] x_old;
		n = 32'(model_window_len);
		if (n == 0) n = 1;
		if (n > WINDOW_DEPTH) n = WINDOW_DEPTH;
		if (r) begin
			model_sum_a = '0;
			model_sum_b = '0;
			model_fill = 0;
			model_wpos = 0;
		end
		if (model_fill >= n) begin
			old_pos = (model_wpos + WINDOW_DEPTH - n) % WINDOW_DEPTH;
			x_old = model_store[old_pos];
			model_sum_a = model_sum_a - SUM_W'(x_old) + SUM_W'(b);
			model_sum_b = model_sum_b - SUM_W'(n * x_old) + model_sum_a;
		end else begin
			model_sum_a = model_sum_a + SUM_W'(b);
			model_sum_b = model_sum_b + model_sum_a;
			model_fill++;
		end
		model_store[model_wpos] = b;
		model_wpos = (model_wpos + 1) % WINDOW_DEPTH;
		expected_checksum.push_back({model_sum_b, model_sum_a});
		expected_full.push_back(model_fill >= n);
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b, input logic r);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_in <= b;
		restart <= r;
		do @(posedge clk); while (!in_ready);
		predict_checksum(b, r);
	endtask

	task automatic wait_results_done();
		in_valid <= 1'b0;
		while (expected_checksum.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_window_len(input logic [CFG_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_window_len = value;
	endtask

	task automatic test_reset_window();
		for (int i = 0; i < 150; i++) begin
			no_idle = (i >= 60 && i < 110);
			send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
		end
		no_idle = 1'b0;
		wait_results_done();
	endtask

	task automatic test_directed();
		write_window_len('0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b0);
		wait_results_done();
		write_window_len(13'd1);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);
		wait_results_done();
		write_window_len(13'd3);
		send_byte(8'hFF, 1'b1);
		repeat (5) send_byte(8'hFF, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'h80, 1'b0);
		send_byte(8'h01, 1'b0);
		send_byte(8'hFF, 1'b0);
		wait_results_done();
		write_window_len(13'd2);
		send_byte(8'h07, 1'b0);
		send_byte(8'h09, 1'b0);
		wait_results_done();
		write_window_len(13'd6);
		send_byte(8'h55, 1'b0);
		send_byte(8'hAA, 1'b0);
		wait_results_done();
	endtask

	task automatic test_long_window();
		write_window_len('1);
		send_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
		for (int i = 0; i < 39; i++) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
		wait_results_done();
		write_window_len(13'd4096);
		repeat (10) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
		wait_results_done();
		write_window_len(13'd4095);
		repeat (10) send_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
		wait_results_done();
	endtask

	task automatic test_random();
		int lens [12];
		int count;
		int restart_odds;
		logic r;
		lens = '{1, 2, 3, 4, 5, 7, 16, 31, 64, 200, 0, 300};
		for (int p = 0; p < 12; p++) begin
			wait_results_done();
			write_window_len(p == 11 ? CFG_W'($urandom_range(1, 300)) : CFG_W'(lens[p]));
			count = $urandom_range(40, 70);
			restart_odds = (p == 9) ? 2 : 39;
			for (int i = 0; i < count; i++) begin
				r = (i == 0 && $urandom_range(0, 2) != 0) || ($urandom_range(0, restart_odds) == 0);
				if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
				if ($urandom_range(0, 149) == 0) wait_results_done();
				send_byte(BYTE_W'($urandom_range(0, 255)), r);
			end
			no_idle = 1'b0;
		end
		wait_results_done();
	endtask

	initial begin
		int gap;
		logic [CSUM_W-1:0] exp_checksum;
		logic exp_full;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			gap = no_idle ? 0 : $urandom_range(0, 18);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (expected_checksum.size() == 0) begin
				$error("result transfer with no expected result: checksum %h", checksum);
				fail_count++;
			end else begin
				exp_checksum = expected_checksum.pop_front();
				exp_full = expected_full.pop_front();
				if (checksum !== exp_checksum) begin
					$error("checksum mismatch: expected %h, actual %h", exp_checksum, checksum);
					fail_count++;
				end
				if (window_full !== exp_full) begin
					$error("window_full mismatch: expected %b, actual %b", exp_full, window_full);
					fail_count++;
				end
			end
		end
	end

	initial begin
		reset_model();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_window();
		test_directed();
		test_long_window();
		test_random();
		wait_results_done();
		if (fail_count == 0)
			$display("rolling_window_checksum test passed");
		else
			$display("rolling_window_checksum test failed");
		$finish;
	end

endmodule
